FILE: design/averaged_level_bar_gauge_macros.svh
// ----------------------------------------------------------------------------
// Averaged level bar gauge assertion macros
// Shorthand for clocked assertions that share the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_LEVEL_BAR_GAUGE_MACROS_SVH
`define AVERAGED_LEVEL_BAR_GAUGE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ALBG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked from the cycle after the antecedent.
`define ALBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/albg_pkg.sv
// ----------------------------------------------------------------------------
// Averaged level bar gauge package
// Widths, reset values, register indexes and shared types of the gauge.
// ----------------------------------------------------------------------------
package albg_pkg;

  // Default averaging window length.
  localparam int unsigned ALBG_WINDOW_LEN = 8;

  // Field widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned BAR_W      = 3;
  localparam int unsigned NUM_BARS   = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Fixed codes of the gauge.
  localparam logic [BAR_W-1:0]   BAR_MAX     = 3'd6;
  localparam logic [LEVEL_W-1:0] LEVEL_FORCE = 8'hFF;

  // Register reset values.
  localparam logic [LEVEL_W-1:0]  ON_THR_1_RST  = 8'h29;
  localparam logic [LEVEL_W-1:0]  ON_THR_2_RST  = 8'h53;
  localparam logic [LEVEL_W-1:0]  ON_THR_3_RST  = 8'h7D;
  localparam logic [LEVEL_W-1:0]  ON_THR_4_RST  = 8'hA6;
  localparam logic [LEVEL_W-1:0]  ON_THR_5_RST  = 8'hD0;
  localparam logic [LEVEL_W-1:0]  ON_THR_6_RST  = 8'hED;
  localparam logic [LEVEL_W-1:0]  HYST_RST      = 8'h05;
  localparam logic [SAMPLE_W-1:0] BAD_LIMIT_RST = 16'd251;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ON_THR_1  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_THR_2  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_THR_3  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_THR_4  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_THR_5  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_THR_6  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_LIMIT = 3'd7;

  // Current register contents.
  typedef struct packed {
    logic [NUM_BARS-1:0][LEVEL_W-1:0] on_thr;
    logic [LEVEL_W-1:0]               hyst;
    logic [SAMPLE_W-1:0]              bad_limit;
  } albg_cfg_t;

  // Decoded control of the transaction being processed.
  typedef struct packed {
    logic fire;     // transaction moves into the result register
    logic set_bar;  // set-bar transaction
    logic ovr;      // external test control owns the gauge
    logic invalid;  // timeout or sample at or above the limit
    logic win_en;   // sample goes into the averaging window
    logic ign;      // preload the window
    logic blink;    // blink phase for the symbol
  } albg_ctrl_t;

endpackage

FILE: design/averaged_level_bar_gauge.sv
// ----------------------------------------------------------------------------
// Averaged level bar gauge
// Turns raw level samples into a 0 to 6 bar count and a symbol flag.
// ----------------------------------------------------------------------------
// The gauge takes one transaction per clock while its input is not stalled
// and returns exactly one result per transaction, in order. A transaction is
// captured in an input register and, once the result register is free or
// being taken, passes through the window update (running sum plus one
// reciprocal multiply for the mean) and the hysteresis threshold chain into
// the result register.
// The result register holds the gauge state itself; while it is stalled the
// input register still takes one more transaction. Configuration registers
// are written through their own port, which is always ready, and must only
// be written while no transaction is in flight.
module averaged_level_bar_gauge #(
  parameter int unsigned WINDOW_LEN = albg_pkg::ALBG_WINDOW_LEN
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [albg_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                              msg_timeout_i,
  input  logic                              sample_ready_i,
  input  logic                              blink_phase_i,
  input  logic                              ignition_reset_i,
  input  logic                              io_override_i,
  input  logic [albg_pkg::LEVEL_W-1:0]      forced_bar_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [albg_pkg::BAR_W-1:0]        bar_count_o,
  output logic                              symbol_on_o,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [albg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [albg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import albg_pkg::*;

  albg_cfg_t  cfg;
  albg_ctrl_t ctrl;

  logic                in_valid_q, in_valid_d;
  logic                out_valid_q, out_valid_d;
  logic                load;
  logic                move;
  logic                invalid;
  logic [SAMPLE_W-1:0] value;
  logic [LEVEL_W-1:0]  level;

  // Captured transaction.
  logic                req_type_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                msg_timeout_q;
  logic                sample_ready_q;
  logic                blink_phase_q;
  logic                ignition_reset_q;
  logic                io_override_q;
  logic [LEVEL_W-1:0]  forced_bar_q;

  // Handshake: the input register drains whenever the result register is
  // free or being taken.
  assign move        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !move;
  assign load        = in_valid_i && !in_stall_o;
  assign in_valid_d  = load || (in_valid_q && !move);
  assign out_valid_d = move || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_type_q       <= req_type_i;
      sample_q         <= sample_i;
      msg_timeout_q    <= msg_timeout_i;
      sample_ready_q   <= sample_ready_i;
      blink_phase_q    <= blink_phase_i;
      ignition_reset_q <= ignition_reset_i;
      io_override_q    <= io_override_i;
      forced_bar_q     <= forced_bar_i;
    end
  end

  // Transaction decode.
  assign invalid = msg_timeout_q || (sample_q >= cfg.bad_limit);
  assign value   = invalid ? '0 : sample_q;

  always_comb begin
    ctrl.fire    = move;
    ctrl.set_bar = req_type_q;
    ctrl.ovr     = io_override_q;
    ctrl.invalid = invalid;
    ctrl.win_en  = !req_type_q && !io_override_q && (invalid || sample_ready_q);
    ctrl.ign     = ignition_reset_q;
    ctrl.blink   = blink_phase_q;
  end

  albg_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  albg_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .value_i (value),
    .level_o (level)
  );

  albg_bar u_bar (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg),
    .forced_bar_i (forced_bar_q),
    .level_i      (level),
    .bar_count_o  (bar_count_o),
    .symbol_on_o  (symbol_on_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/albg_cfg_regs.sv
// ----------------------------------------------------------------------------
// Gauge configuration registers
// Threshold, hysteresis and bad-data limit registers behind the write port.
// ----------------------------------------------------------------------------
module albg_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [albg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [albg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output albg_pkg::albg_cfg_t                 cfg_o
);
  import albg_pkg::*;

  albg_cfg_t cfg_q, cfg_d;
  logic [LEVEL_W-1:0] data8;

  // Every write is taken at once.
  assign cfg_ready_o = 1'b1;
  assign data8       = cfg_data_i[LEVEL_W-1:0];

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ON_THR_1:  cfg_d.on_thr[0] = data8;
        CFG_ON_THR_2:  cfg_d.on_thr[1] = data8;
        CFG_ON_THR_3:  cfg_d.on_thr[2] = data8;
        CFG_ON_THR_4:  cfg_d.on_thr[3] = data8;
        CFG_ON_THR_5:  cfg_d.on_thr[4] = data8;
        CFG_ON_THR_6:  cfg_d.on_thr[5] = data8;
        CFG_HYST:      cfg_d.hyst      = data8;
        CFG_BAD_LIMIT: cfg_d.bad_limit = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_thr[0]  <= ON_THR_1_RST;
      cfg_q.on_thr[1]  <= ON_THR_2_RST;
      cfg_q.on_thr[2]  <= ON_THR_3_RST;
      cfg_q.on_thr[3]  <= ON_THR_4_RST;
      cfg_q.on_thr[4]  <= ON_THR_5_RST;
      cfg_q.on_thr[5]  <= ON_THR_6_RST;
      cfg_q.hyst       <= HYST_RST;
      cfg_q.bad_limit  <= BAD_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/albg_window.sv
// ----------------------------------------------------------------------------
// Gauge averaging window
// Sliding window with a running sum and a reciprocal divide for the mean.
// ----------------------------------------------------------------------------
module albg_window #(
  parameter int unsigned WINDOW_LEN = albg_pkg::ALBG_WINDOW_LEN
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  albg_pkg::albg_ctrl_t              ctrl_i,
  input  logic [albg_pkg::SAMPLE_W-1:0]     value_i,
  output logic [albg_pkg::LEVEL_W-1:0]      level_o
);
  import albg_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W = SAMPLE_W + IDX_W;
  // Exact floor division by the window length: ceil(2^K / N) times the sum,
  // shifted down by K, is exact for every sum below 2^SUM_W.
  localparam int unsigned K      = SUM_W + IDX_W;
  localparam int unsigned RW     = K - IDX_W + 1;
  localparam int unsigned PW     = SUM_W + RW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RW-1:0]    RECIP = RW'(RECIP_L);
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(WINDOW_LEN - 1);

  // Entries 0 .. N-2; the newest entry of a full window never needs storing.
  logic [SAMPLE_W-1:0] win_q [WINDOW_LEN-1];
  logic [SAMPLE_W-1:0] win_d [WINDOW_LEN-1];
  logic [IDX_W-1:0]    fill_q, fill_d;
  logic [SUM_W-1:0]    sum_q, sum_d;       // sum of entries below fill_q
  logic [LEVEL_W-1:0]  avg_q, avg_d;

  logic                wr;
  logic [IDX_W-1:0]    base_fill;
  logic [SUM_W-1:0]    value_ext;
  logic [SUM_W-1:0]    preload_sum;
  logic [SUM_W-1:0]    base_sum;
  logic [SUM_W-1:0]    total;
  logic [SAMPLE_W-1:0] oldest;
  logic                full;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       quot;

  assign wr          = ctrl_i.fire && ctrl_i.win_en;
  assign value_ext   = {{IDX_W{1'b0}}, value_i};
  assign preload_sum = SUM_W'(value_ext * SUM_W'(WINDOW_LEN - 1));

  // Ignition preload fills the window with the sample before the write.
  assign base_fill = ctrl_i.ign ? LAST : fill_q;
  assign base_sum  = ctrl_i.ign ? preload_sum : sum_q;
  assign oldest    = ctrl_i.ign ? value_i : win_q[0];
  assign total     = base_sum + value_ext;
  assign full      = (base_fill == LAST);

  // Mean of a full window.
  assign prod = {{RW{1'b0}}, total} * {{SUM_W{1'b0}}, RECIP};
  assign quot = prod >> K;

  // Window update: append while filling, slide once full.
  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    avg_d  = avg_q;
    if (wr) begin
      if (full) begin
        // A full window, preloaded or not, stays one entry short of full.
        fill_d = LAST;
        avg_d  = quot[LEVEL_W-1:0];
        sum_d  = total - {{IDX_W{1'b0}}, oldest};
        for (int i = 0; i < int'(WINDOW_LEN) - 2; i++) begin
          win_d[i] = ctrl_i.ign ? value_i : win_q[i+1];
        end
        win_d[WINDOW_LEN-2] = value_i;
      end else begin
        fill_d = fill_q + IDX_W'(1);
        sum_d  = total;
        for (int i = 0; i < int'(WINDOW_LEN) - 1; i++) begin
          if (fill_q == IDX_W'(i)) begin
            win_d[i] = value_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
      avg_q  <= '0;
    end else begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
      avg_q  <= avg_d;
    end
  end

  // Window entries are always written before they are read.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign level_o = avg_d;

endmodule

FILE: design/albg_bar.sv
// ----------------------------------------------------------------------------
// Gauge bar and symbol state
// Hysteresis threshold chain, set-bar handling and the result register.
// ----------------------------------------------------------------------------
module albg_bar (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  albg_pkg::albg_ctrl_t              ctrl_i,
  input  albg_pkg::albg_cfg_t               cfg_i,
  input  logic [albg_pkg::LEVEL_W-1:0]      forced_bar_i,
  input  logic [albg_pkg::LEVEL_W-1:0]      level_i,
  output logic [albg_pkg::BAR_W-1:0]        bar_count_o,
  output logic                              symbol_on_o
);
  import albg_pkg::*;

  logic [BAR_W-1:0]   bar_q, bar_d;
  logic               sym_q, sym_d;
  logic [LEVEL_W-1:0] last_q, last_d;
  logic [BAR_W-1:0]   forced_sat;

  // Ascending tests first, then descending tests; the first hit wins.
  function automatic logic [BAR_W-1:0] run_chain(input logic [LEVEL_W-1:0] lv,
                                                 input logic [BAR_W-1:0]   b,
                                                 input albg_cfg_t          cfg);
    logic [BAR_W-1:0] res;
    logic             hit;
    res = b;
    hit = 1'b0;
    if (b == '0 && lv < cfg.on_thr[0]) begin
      res = '0;
      hit = 1'b1;
    end
    for (int k = 1; k < int'(NUM_BARS); k++) begin
      if (!hit && b <= BAR_W'(k) && lv >= cfg.on_thr[k-1] && lv < cfg.on_thr[k]) begin
        res = BAR_W'(k);
        hit = 1'b1;
      end
    end
    if (!hit && b <= BAR_MAX && lv >= cfg.on_thr[NUM_BARS-1]) begin
      res = BAR_MAX;
      hit = 1'b1;
    end
    // Off threshold is on minus hysteresis; a negative one never matches.
    for (int k = 1; k <= int'(NUM_BARS); k++) begin
      if (!hit && b > BAR_W'(k - 1) && cfg.on_thr[k-1] >= cfg.hyst &&
          ({1'b0, lv} + {1'b0, cfg.hyst}) <= {1'b0, cfg.on_thr[k-1]}) begin
        res = BAR_W'(k - 1);
        hit = 1'b1;
      end
    end
    return res;
  endfunction

  assign forced_sat = (forced_bar_i > LEVEL_W'(BAR_MAX)) ? BAR_MAX
                                                         : forced_bar_i[BAR_W-1:0];

  // Next state for the transaction leaving the input register.
  always_comb begin
    bar_d  = bar_q;
    sym_d  = sym_q;
    last_d = last_q;
    if (ctrl_i.fire) begin
      if (ctrl_i.set_bar) begin
        bar_d = forced_sat;
      end else if (ctrl_i.ovr) begin
        sym_d  = 1'b1;
        last_d = LEVEL_FORCE;
      end else begin
        sym_d = ctrl_i.invalid ? ctrl_i.blink : 1'b1;
        if (ctrl_i.win_en && level_i != last_q) begin
          last_d = level_i;
          bar_d  = run_chain(level_i, bar_q, cfg_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_q  <= '0;
      sym_q  <= 1'b0;
      last_q <= '0;
    end else begin
      bar_q  <= bar_d;
      sym_q  <= sym_d;
      last_q <= last_d;
    end
  end

  assign bar_count_o = bar_q;
  assign symbol_on_o = sym_q;

endmodule

FILE: design/albg_checker.sv
// ----------------------------------------------------------------------------
// Averaged level bar gauge checker
// Port-level assertions on the gauge, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "averaged_level_bar_gauge_macros.svh"

module albg_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [albg_pkg::BAR_W-1:0]        bar_count_o,
  input  logic                              symbol_on_o
);
  import albg_pkg::*;

  logic           in_take;
  logic           out_wait;
  logic [BAR_W:0] out_data;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_wait = out_valid_o && out_stall_i;
  assign out_data = {bar_count_o, symbol_on_o};

  // The bar count of a valid result never leaves its range.
  `ALBG_ASSERT_NOW(a_bar_range, out_valid_o, bar_count_o <= BAR_MAX, "bar count above six")

  // The input side only stalls behind a stalled result.
  `ALBG_ASSERT_NOW(a_stall_cause, in_stall_o, out_wait, "input stalled without output stall")

  // After a transaction is accepted with the result register empty, the result register holds a valid result.
  `ALBG_ASSERT_NEXT(a_latency, in_take && !out_valid_o, ##1 out_valid_o, "result missing")

  // A stalled result holds.
  `ALBG_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_data), "stalled result changed")

endmodule

bind averaged_level_bar_gauge albg_checker u_albg_checker (.*);
